// ===== src/lexeme_class_recognizer_defines.svh =====
// Assertion macros shared by the verification files of the lexeme class recognizer.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef LEXEME_CLASS_RECOGNIZER_DEFINES_SVH
`define LEXEME_CLASS_RECOGNIZER_DEFINES_SVH

// Same-cycle implication.
`define LCR_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexeme_class_recognizer check failed");

// Next-cycle implication.
`define LCR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexeme_class_recognizer check failed");

`endif

// ===== src/lcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcr_pkg
// Class codes, character constants, token tracking state and the character
// tests shared by the lexeme class recognizer.
// ----------------------------------------------------------------------------
package lcr_pkg;

    localparam logic [2:0] CLS_NULL   = 3'd0;
    localparam logic [2:0] CLS_BOOL   = 3'd1;
    localparam logic [2:0] CLS_IDENT  = 3'd2;
    localparam logic [2:0] CLS_INT    = 3'd3;
    localparam logic [2:0] CLS_FLOAT  = 3'd4;
    localparam logic [2:0] CLS_BLANK  = 3'd5;
    localparam logic [2:0] CLS_STRING = 3'd6;
    localparam logic [2:0] CLS_SYMBOL = 3'd7;

    localparam logic [2:0] COUNT_MAX = 3'd6;

    localparam logic [7:0] CH_UNDER  = "_";
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_QUOTE  = "'";
    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_GT     = ">";
    localparam logic [7:0] CH_LT     = "<";
    localparam logic [7:0] CH_AMP    = "&";
    localparam logic [7:0] CH_BAR    = "|";
    localparam logic [7:0] CH_BANG   = "!";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_EQ     = "=";
    localparam logic [7:0] CH_LBRACK = "[";
    localparam logic [7:0] CH_RBRACK = "]";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_NONE   = 8'h00;

    localparam logic [7:0] CH_T = "t";
    localparam logic [7:0] CH_R = "r";
    localparam logic [7:0] CH_U = "u";
    localparam logic [7:0] CH_E = "e";
    localparam logic [7:0] CH_F = "f";
    localparam logic [7:0] CH_A = "a";
    localparam logic [7:0] CH_L = "l";
    localparam logic [7:0] CH_S = "s";

    typedef struct packed {
        logic [2:0] char_count;
        logic       ident_ok;
        logic       int_ok;
        logic       float_ok;
        logic       dot_seen;
        logic       blank_ok;
        logic       first_quote;
        logic       true_match;
        logic       false_match;
        logic [7:0] first_char;
        logic [7:0] second_char;
    } tok_state_t;

    localparam tok_state_t TOK_CLEAR = '{
        char_count:  3'd0,
        ident_ok:    1'b1,
        int_ok:      1'b1,
        float_ok:    1'b1,
        dot_seen:    1'b0,
        blank_ok:    1'b1,
        first_quote: 1'b0,
        true_match:  1'b1,
        false_match: 1'b1,
        first_char:  8'h00,
        second_char: 8'h00
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic [7:0] true_char(input logic [1:0] pos);
        logic [7:0] ch;
        case (pos)
            2'd0:    ch = CH_T;
            2'd1:    ch = CH_R;
            2'd2:    ch = CH_U;
            default: ch = CH_E;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] false_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = CH_F;
            3'd1:    ch = CH_A;
            3'd2:    ch = CH_L;
            3'd3:    ch = CH_S;
            3'd4:    ch = CH_E;
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

    function automatic logic is_single_sym(input logic [7:0] c);
        logic hit;
        case (c)
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_GT, CH_LT, CH_AMP,
            CH_BAR, CH_BANG, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
            CH_EQ, CH_LBRACK, CH_RBRACK, CH_COMMA, CH_DOT, CH_QUOTE,
            CH_SEMI, CH_UNDER: hit = 1'b1;
            default:           hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic is_pair_sym(input logic [7:0] a, input logic [7:0] b);
        return ((a == CH_GT)   && (b == CH_EQ))
            || ((a == CH_LT)   && (b == CH_EQ))
            || ((a == CH_LT)   && (b == CH_MINUS))
            || ((a == CH_BANG) && (b == CH_EQ))
            || ((a == CH_AMP)  && (b == CH_AMP))
            || ((a == CH_BAR)  && (b == CH_BAR))
            || ((a == CH_EQ)   && (b == CH_EQ));
    endfunction

endpackage
`default_nettype wire

// ===== src/lexeme_class_recognizer.sv =====
// Throughput: one character beat per cycle unless stalled, with no bubbles between tokens.
// A last character passes through the input register and then the result register before
// its class is offered on the result channel.
// The input stalls only while a finished result waits and the held character ends a token.
// Reset clears the token flags, both valid bits and the ignore_symbols register.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lexeme_class_recognizer
// Classifies a token streamed one character per beat and offers one class
// code per token on the result channel.
// ----------------------------------------------------------------------------
module lexeme_class_recognizer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_code,
    input  wire logic       last_char,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      token_class,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       ignore_symbols
);
    import lcr_pkg::*;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [2:0] out_class_reg;
    logic       ign_reg;
    logic       ign_next;
    logic       in_acc;
    logic       s1_adv;
    logic       out_load;
    logic [2:0] class_next;
    tok_state_t upd;

    lcr_token_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_adv),
        .last_char (s1_last_reg),
        .char_code (s1_char_reg),
        .upd       (upd)
    );

    lcr_class_logic u_class (
        .upd            (upd),
        .char_code      (s1_char_reg),
        .ignore_symbols (ign_reg),
        .token_class    (class_next)
    );

    always_comb
    begin
        s1_adv    = s1_valid_reg && (!s1_last_reg || !out_valid_reg || !out_stall);
        in_stall  = s1_valid_reg && !s1_adv;
        in_acc    = in_valid && !in_stall;
        out_load  = s1_adv && s1_last_reg;
        cfg_ready = 1'b1;

        s1_valid_next = s1_valid_reg;
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        ign_next = ign_reg;
        if (cfg_valid && cfg_ready)
        begin
            ign_next = ignore_symbols;
        end

        out_valid   = out_valid_reg;
        token_class = out_class_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ign_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            ign_reg       <= ign_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_char_reg <= char_code;
            s1_last_reg <= last_char;
        end
        if (out_load)
        begin
            out_class_reg <= class_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/lcr_token_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcr_token_tracker
// Holds the running flags of the token in progress and works out their
// updated values for the current character.
// ----------------------------------------------------------------------------
module lcr_token_tracker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic               last_char,
    input  wire logic [7:0]         char_code,
    output lcr_pkg::tok_state_t     upd
);
    import lcr_pkg::*;

    tok_state_t st_reg;
    tok_state_t st_next;
    logic [2:0] pos;
    logic       dig;

    always_comb
    begin
        upd = st_reg;
        pos = st_reg.char_count;
        dig = is_digit(char_code);
        if (pos == 3'd0)
        begin
            upd.first_char  = char_code;
            upd.ident_ok    = is_alpha(char_code) || (char_code == CH_UNDER);
            upd.int_ok      = dig || is_sign(char_code);
            upd.float_ok    = dig || is_sign(char_code);
            upd.first_quote = (char_code == CH_QUOTE);
        end
        else
        begin
            if (pos == 3'd1)
            begin
                upd.second_char = char_code;
            end
            if (!(is_alpha(char_code) || dig || (char_code == CH_UNDER)))
            begin
                upd.ident_ok = 1'b0;
            end
            if (!dig)
            begin
                upd.int_ok = 1'b0;
            end
            if (char_code == CH_DOT)
            begin
                if (st_reg.dot_seen)
                begin
                    upd.float_ok = 1'b0;
                end
                upd.dot_seen = 1'b1;
            end
            else if (!dig)
            begin
                upd.float_ok = 1'b0;
            end
        end
        if (!is_blank(char_code))
        begin
            upd.blank_ok = 1'b0;
        end
        if ((pos >= 3'd4) || (true_char(pos[1:0]) != char_code))
        begin
            upd.true_match = 1'b0;
        end
        if ((pos >= 3'd5) || (false_char(pos) != char_code))
        begin
            upd.false_match = 1'b0;
        end
        if (pos < COUNT_MAX)
        begin
            upd.char_count = pos + 3'd1;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        if (step)
        begin
            st_next = last_char ? TOK_CLEAR : upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= TOK_CLEAR;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/lcr_class_logic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcr_class_logic
// Picks the class code of a finished token from its updated flags, in
// priority order, with the symbol override on top.
// ----------------------------------------------------------------------------
module lcr_class_logic (
    input  wire lcr_pkg::tok_state_t upd,
    input  wire logic [7:0]          char_code,
    input  wire logic                ignore_symbols,
    output logic [2:0]               token_class
);
    import lcr_pkg::*;

    logic lone_sign;
    logic int_f;
    logic float_f;
    logic bool_f;
    logic string_f;
    logic symbol_f;

    always_comb
    begin
        lone_sign = (upd.char_count == 3'd1) && is_sign(upd.first_char);
        int_f     = upd.int_ok && !lone_sign;
        float_f   = upd.float_ok && !lone_sign
                    && !((upd.char_count >= 3'd2) && !is_digit(char_code));
        bool_f    = (upd.true_match && (upd.char_count == 3'd4))
                    || (upd.false_match && (upd.char_count == 3'd5));
        string_f  = (upd.char_count >= 3'd2) && upd.first_quote && (char_code == CH_QUOTE);
        symbol_f  = ((upd.char_count == 3'd1) && is_single_sym(upd.first_char))
                    || ((upd.char_count == 3'd2)
                        && is_pair_sym(upd.first_char, upd.second_char));

        if (bool_f)
        begin
            token_class = CLS_BOOL;
        end
        else if (upd.ident_ok)
        begin
            token_class = CLS_IDENT;
        end
        else if (int_f)
        begin
            token_class = CLS_INT;
        end
        else if (float_f)
        begin
            token_class = CLS_FLOAT;
        end
        else if (upd.blank_ok)
        begin
            token_class = CLS_BLANK;
        end
        else if (string_f)
        begin
            token_class = CLS_STRING;
        end
        else
        begin
            token_class = CLS_NULL;
        end

        if (!ignore_symbols && symbol_f)
        begin
            token_class = CLS_SYMBOL;
        end
    end

endmodule
`default_nettype wire

// ===== src/lcr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "lexeme_class_recognizer_defines.svh"
// ----------------------------------------------------------------------------
// lcr_checker
// Port-level checks of the lexeme class recognizer, bound to the top level.
// ----------------------------------------------------------------------------
module lcr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [7:0] char_code,
    input wire logic       last_char,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [2:0] token_class,
    input wire logic       cfg_valid,
    input wire logic       cfg_ready,
    input wire logic       ignore_symbols
);

    logic unused_ok;

    assign unused_ok = ^{char_code, cfg_valid, cfg_ready, ignore_symbols};

    `LCR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(token_class))
    `LCR_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)
    `LCR_ASSERT_IMPL(a_result_origin, $rose(out_valid), $past(in_valid && !in_stall && last_char, 2))

endmodule

bind lexeme_class_recognizer lcr_checker u_lcr_checker (.*);
`default_nettype wire
